### src/cle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg: shared types and constants
// Defaults, configuration register indexes and control structs used by the
// crack line / element edge intersection unit and its submodules.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int COORD_BITS_DEF      = 24;
  localparam int RATIO_FRAC_BITS_DEF = 24;
  localparam int CFG_IDX_BITS        = 2;

  // Reset point of the crack tip, x in Q12.12 (one unit)
  localparam int TIP_X_RESET = 4096;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_START_X = 2'd0,
    CFG_START_Y = 2'd1,
    CFG_TIP_X   = 2'd2,
    CFG_TIP_Y   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MAC_LOAD = 2'd0,
    MAC_ADD  = 2'd1,
    MAC_SUB  = 2'd2
  } mac_op_t;

  typedef struct packed {
    logic    valid;
    mac_op_t op;
  } mac_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### src/cle_node_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_node_if: element node channel
// Valid/ready channel carrying one element node per transfer.
// ----------------------------------------------------------------------------
interface cle_node_if #(
  parameter int COORD_BITS = cle_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] node_x;
  logic signed [COORD_BITS-1:0] node_y;
  logic                         last_node;

  modport source (output valid, node_x, node_y, last_node, input ready);
  modport sink   (input valid, node_x, node_y, last_node, output ready);
endinterface

### src/cle_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_result_if: result channel
// Valid/ready channel carrying crossing points and element summaries.
// ----------------------------------------------------------------------------
interface cle_result_if #(
  parameter int COORD_BITS = cle_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic [1:0]                   crossings;
  logic                         last;

  modport source (output valid, kind, point_x, point_y, crossings, last, input ready);
  modport sink   (input valid, kind, point_x, point_y, crossings, last, output ready);
endinterface

### src/cle_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_mac: shared multiply-accumulate unit
// Signed multiply with a registered product, then load/add/subtract into
// the accumulator in the following cycle.
// ----------------------------------------------------------------------------
module cle_mac #(
  parameter int MW = cle_pkg::COORD_BITS_DEF + 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cle_pkg::mac_cmd_t        cmd,
  input  logic signed [MW-1:0]     op_a,
  input  logic signed [MW-1:0]     op_b,
  output logic signed [2*MW-1:0]   acc
);
  import cle_pkg::*;

  logic signed [2*MW-1:0] prod_r;
  logic signed [2*MW-1:0] acc_r;
  mac_cmd_t               cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= '0;
    end else begin
      cmd_r <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (cmd_r.valid) begin
      case (cmd_r.op)
        MAC_LOAD: acc_r <= prod_r;
        MAC_ADD:  acc_r <= acc_r + prod_r;
        MAC_SUB:  acc_r <= acc_r - prod_r;
        default:  acc_r <= acc_r;
      endcase
    end
  end

  assign acc = acc_r;

endmodule

### src/cle_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_divider: serial ratio divider
// Restoring division num * 2^F / den, one quotient bit a cycle, then one
// rounding step (nearest, ties up). Requires num < den.
// ----------------------------------------------------------------------------
module cle_divider #(
  parameter int NW = 2 * cle_pkg::COORD_BITS_DEF + 4,
  parameter int F  = cle_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NW-1:0]        num,
  input  logic [NW:0]          den,
  output logic [F:0]           quot,
  output cle_pkg::div_stat_t   stat
);
  import cle_pkg::*;

  localparam int CW = $clog2(F + 1);

  logic [NW+1:0] rem_r;
  logic [NW:0]   den_r;
  logic [F:0]    q_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [NW+1:0] rem_sh;
  logic          ge;

  assign rem_sh = {rem_r[NW:0], 1'b0};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= {2'b00, num};
        den_r  <= den;
        q_r    <= '0;
      end else if (busy_r) begin
        if (cnt_r == CW'(F)) begin
          // rounding step
          if (ge) q_r <= q_r + 1'b1;
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          q_r   <= {q_r[F-1:0], ge};
          rem_r <= ge ? rem_sh - {1'b0, den_r} : rem_sh;
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign quot      = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

### src/crack_line_element_intersection_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crack_line_element_intersection_unit: crack line / element edge crossings
// Sequence: a node is accepted, its level-set products are formed on the
//   shared multiplier, the edge is tested and the node is committed; the
//   first node of an element that does not end it skips the edge test.
//   A last node adds an edge test for the closing edge and the element
//   summary. Each crossing edge adds a serial divide, two scaling products
//   (one for x, one for y) and an emit.
// Throughput: a new node is taken only once the last one is through; the
//   shared multiplier and the serial divider set the pace, plus any wait of
//   an emit or the summary for the result register to drain.
// Reset: synchronous active-low; line resets to (0,0)->(4096,0), next node
//   starts an element, no result pending.
// ----------------------------------------------------------------------------
module crack_line_element_intersection_unit #(
  parameter int COORD_BITS      = cle_pkg::COORD_BITS_DEF,
  parameter int RATIO_FRAC_BITS = cle_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [cle_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [COORD_BITS-1:0]                cfg_data,
  cle_node_if.sink                             in_node,
  cle_result_if.source                         out_result
);
  import cle_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int F  = RATIO_FRAC_BITS;
  // multiplier operand width covers a coordinate difference and the ratio
  localparam int MW = (C + 2 > F + 2) ? C + 2 : F + 2;
  // level-set value width
  localparam int W  = 2 * C + 4;
  localparam logic [2*MW-1:0] RND = (2*MW)'(1) << (F - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LS, S_EDGE, S_DIV, S_SCX, S_SCY, S_EMIT, S_SUM, S_DONE
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration: crack start and tip points
  // --------------------------------------------------------------------------
  logic signed [C-1:0] sx_r, sy_r, tx_r, ty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0;
      sy_r <= '0;
      tx_r <= C'(TIP_X_RESET);
      ty_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_START_X: sx_r <= cfg_data;
        CFG_START_Y: sy_r <= cfg_data;
        CFG_TIP_X:   tx_r <= cfg_data;
        CFG_TIP_Y:   ty_r <= cfg_data;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state and per-element storage
  // --------------------------------------------------------------------------
  state_t              state_r;
  logic [2:0]          step_r;
  logic                at_start_r;
  logic                edge_sel_r;   // 0: previous->current, 1: closing edge
  logic                last_r;
  logic signed [C-1:0] x_r, y_r;
  logic signed [W-1:0] n_r, t_r;
  logic signed [C-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic signed [W-1:0] first_n_r, first_t_r, prev_n_r, prev_t_r;
  logic signed [W-1:0] nmin_r, nmax_r, tmin_r, tmax_r;

  // edge under test
  logic signed [C-1:0] ex1_r, ey1_r;
  logic [C:0]          adx_r, ady_r;
  logic                dxn_r, dyn_r;
  logic [F:0]          r_r;
  logic signed [C-1:0] px_r;
  logic signed [C-1:0] py_r;

  // result register
  logic                out_valid_r;
  logic                out_kind_r;
  logic signed [C-1:0] out_px_r, out_py_r;
  logic [1:0]          out_cross_r;
  logic                out_last_r;

  // --------------------------------------------------------------------------
  // Shared multiplier operands
  // --------------------------------------------------------------------------
  function automatic logic signed [MW-1:0] ext1(input logic signed [C:0] v);
    ext1 = {{(MW-C-1){v[C]}}, v};
  endfunction

  function automatic logic signed [MW-1:0] ext0(input logic signed [C-1:0] v);
    ext0 = {{(MW-C){v[C-1]}}, v};
  endfunction

  logic signed [C:0]      a_c, b_c, py_c, dxt_c, dyt_c;
  mac_cmd_t               mac_cmd;
  logic signed [MW-1:0]   op_a, op_b;
  logic signed [2*MW-1:0] acc;

  assign a_c   = {sy_r[C-1], sy_r} - {ty_r[C-1], ty_r};
  assign b_c   = {tx_r[C-1], tx_r} - {sx_r[C-1], sx_r};
  assign py_c  = {ty_r[C-1], ty_r} - {sy_r[C-1], sy_r};
  assign dxt_c = {x_r[C-1], x_r} - {tx_r[C-1], tx_r};
  assign dyt_c = {y_r[C-1], y_r} - {ty_r[C-1], ty_r};

  always_comb begin
    mac_cmd = '{valid: 1'b0, op: MAC_LOAD};
    op_a    = '0;
    op_b    = '0;
    case (state_r)
      S_LS: begin
        case (step_r)
          3'd0: begin
            mac_cmd = '{valid: 1'b1, op: MAC_LOAD};
            op_a = ext1(a_c);  op_b = ext0(x_r);
          end
          3'd1: begin
            mac_cmd = '{valid: 1'b1, op: MAC_ADD};
            op_a = ext1(b_c);  op_b = ext0(y_r);
          end
          3'd2: begin
            mac_cmd = '{valid: 1'b1, op: MAC_ADD};
            op_a = ext0(sx_r); op_b = ext0(ty_r);
          end
          3'd3: begin
            mac_cmd = '{valid: 1'b1, op: MAC_SUB};
            op_a = ext0(tx_r); op_b = ext0(sy_r);
          end
          3'd4: begin
            mac_cmd = '{valid: 1'b1, op: MAC_LOAD};
            op_a = ext1(dxt_c); op_b = ext1(b_c);
          end
          3'd5: begin
            mac_cmd = '{valid: 1'b1, op: MAC_ADD};
            op_a = ext1(dyt_c); op_b = ext1(py_c);
          end
          default: ;
        endcase
      end
      S_SCX, S_SCY: begin
        if (step_r == 3'd0) begin
          mac_cmd = '{valid: 1'b1, op: MAC_LOAD};
          op_a    = {{(MW-F-1){1'b0}}, r_r};
          op_b    = {{(MW-C-1){1'b0}}, (state_r == S_SCX) ? adx_r : ady_r};
        end
      end
      default: ;
    endcase
  end

  cle_mac #(.MW(MW)) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mac_cmd),
    .op_a  (op_a),
    .op_b  (op_b),
    .acc   (acc)
  );

  // --------------------------------------------------------------------------
  // Edge test and divider launch
  // --------------------------------------------------------------------------
  logic signed [C-1:0] e_x1, e_y1, e_x2, e_y2;
  logic signed [W-1:0] e_n1, e_t1, e_n2, e_t2;
  logic [W-1:0]        mag1, mag2;
  logic                edge_hit;
  logic signed [C:0]   e_dx, e_dy;
  logic                div_start;
  logic [F:0]          div_quot;
  div_stat_t           div_stat;
  state_t              after_edge;

  always_comb begin
    if (edge_sel_r) begin
      e_x1 = x_r;       e_y1 = y_r;       e_n1 = n_r;       e_t1 = t_r;
      e_x2 = first_x_r; e_y2 = first_y_r; e_n2 = first_n_r; e_t2 = first_t_r;
    end else begin
      e_x1 = prev_x_r;  e_y1 = prev_y_r;  e_n1 = prev_n_r;  e_t1 = prev_t_r;
      e_x2 = x_r;       e_y2 = y_r;       e_n2 = n_r;       e_t2 = t_r;
    end
  end

  assign mag1     = e_n1[W-1] ? -e_n1 : e_n1;
  assign mag2     = e_n2[W-1] ? -e_n2 : e_n2;
  assign edge_hit = ((e_n1 < 0 && e_n2 > 0) || (e_n1 > 0 && e_n2 < 0)) &&
                    (e_t1 < 0) && (e_t2 < 0);
  assign e_dx     = {e_x2[C-1], e_x2} - {e_x1[C-1], e_x1};
  assign e_dy     = {e_y2[C-1], e_y2} - {e_y1[C-1], e_y1};
  assign div_start = (state_r == S_EDGE) && edge_hit;

  // after the current edge: closing edge, summary, or commit
  assign after_edge = (!edge_sel_r && last_r) ? S_EDGE :
                      (edge_sel_r ? S_SUM : S_DONE);

  cle_divider #(.NW(W), .F(F)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mag1),
    .den   ({1'b0, mag1} + {1'b0, mag2}),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  // --------------------------------------------------------------------------
  // Scaled offset along the edge: round(r * |d| / 2^F), applied to p1
  // --------------------------------------------------------------------------
  logic [2*MW-1:0]     sc_sum;
  logic [C:0]          sc_mag;
  logic signed [C:0]   base_x, base_y;
  logic signed [C:0]   pnt_x, pnt_y;
  logic signed [W-1:0] t_now;
  logic [1:0]          sum_count;

  assign sc_sum = acc + RND;
  assign sc_mag = sc_sum[F+C:F];
  assign base_x = {ex1_r[C-1], ex1_r};
  assign base_y = {ey1_r[C-1], ey1_r};
  assign pnt_x  = dxn_r ? base_x - sc_mag : base_x + sc_mag;
  assign pnt_y  = dyn_r ? base_y - sc_mag : base_y + sc_mag;
  assign t_now  = acc[W-1:0];

  always_comb begin
    sum_count = 2'd0;
    if (nmax_r > 0 && nmin_r < 0) begin
      if (tmax_r < 0)                    sum_count = 2'd2;
      else if (tmax_r > 0 && tmin_r < 0) sum_count = 2'd1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      at_start_r  <= 1'b1;
      edge_sel_r  <= 1'b0;
      out_valid_r <= 1'b0;
      first_x_r   <= '0;
      first_y_r   <= '0;
      first_n_r   <= '0;
      first_t_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_n_r    <= '0;
      prev_t_r    <= '0;
      nmin_r      <= '0;
      nmax_r      <= '0;
      tmin_r      <= '0;
      tmax_r      <= '0;
    end else begin
      // drop the result once transferred, unless a new one loads this cycle
      if (out_valid_r && out_result.ready && !(state_r inside {S_EMIT, S_SUM}))
        out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_node.valid) begin
            x_r     <= in_node.node_x;
            y_r     <= in_node.node_y;
            last_r  <= in_node.last_node;
            step_r  <= '0;
            state_r <= S_LS;
          end
        end

        S_LS: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd5) n_r <= acc[W-1:0];
          if (step_r == 3'd7) begin
            t_r <= t_now;
            if (at_start_r) begin
              first_x_r <= x_r;
              first_y_r <= y_r;
              first_n_r <= n_r;
              first_t_r <= t_now;
              nmin_r    <= n_r;
              nmax_r    <= n_r;
              tmin_r    <= t_now;
              tmax_r    <= t_now;
            end else begin
              if (n_r < nmin_r)   nmin_r <= n_r;
              if (n_r > nmax_r)   nmax_r <= n_r;
              if (t_now < tmin_r) tmin_r <= t_now;
              if (t_now > tmax_r) tmax_r <= t_now;
            end
            edge_sel_r <= at_start_r;
            if (!at_start_r || last_r) state_r <= S_EDGE;
            else                       state_r <= S_DONE;
          end
        end

        S_EDGE: begin
          if (edge_hit) begin
            ex1_r   <= e_x1;
            ey1_r   <= e_y1;
            adx_r   <= e_dx[C] ? -e_dx : e_dx;
            ady_r   <= e_dy[C] ? -e_dy : e_dy;
            dxn_r   <= e_dx[C];
            dyn_r   <= e_dy[C];
            state_r <= S_DIV;
          end else begin
            edge_sel_r <= 1'b1;
            state_r    <= after_edge;
          end
        end

        S_DIV: begin
          if (div_stat.done) begin
            r_r     <= div_quot;
            step_r  <= '0;
            state_r <= S_SCX;
          end
        end

        S_SCX: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd2) begin
            px_r    <= pnt_x[C-1:0];
            step_r  <= '0;
            state_r <= S_SCY;
          end
        end

        S_SCY: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd2) begin
            py_r    <= pnt_y[C-1:0];
            state_r <= S_EMIT;
          end
        end

        S_EMIT: begin
          // hold until the result register is free
          if (!out_valid_r || out_result.ready) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= 1'b0;
            out_px_r    <= px_r;
            out_py_r    <= py_r;
            out_cross_r <= 2'd0;
            out_last_r  <= 1'b0;
            edge_sel_r  <= 1'b1;
            state_r     <= after_edge;
          end
        end

        S_SUM: begin
          if (!out_valid_r || out_result.ready) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= 1'b1;
            out_px_r    <= '0;
            out_py_r    <= '0;
            out_cross_r <= sum_count;
            out_last_r  <= 1'b1;
            state_r     <= S_DONE;
          end
        end

        S_DONE: begin
          // commit this node as the previous one
          prev_x_r   <= x_r;
          prev_y_r   <= y_r;
          prev_n_r   <= n_r;
          prev_t_r   <= t_r;
          at_start_r <= last_r;
          state_r    <= S_IDLE;
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_node.ready        = (state_r == S_IDLE);
  assign out_result.valid     = out_valid_r;
  assign out_result.kind      = out_kind_r;
  assign out_result.point_x   = out_px_r;
  assign out_result.point_y   = out_py_r;
  assign out_result.crossings = out_cross_r;
  assign out_result.last      = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_summary_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_kind_r == out_last_r))
    else $error("summary flag and last flag disagree");

  a_point_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_kind_r) |-> (out_cross_r == 2'd0))
    else $error("crossing point carries a count");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == S_DIV))
    else $error("divider busy outside divide state");

  a_div_start_from_edge: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(div_stat.busy) |-> ($past(state_r) == S_EDGE))
    else $error("divider started outside edge test");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: crack line / element edge intersection unit testbench
// Streams element nodes across several crack line settings, predicts every
// crossing point and element summary in a scoreboard, and checks each result
// transfer in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import cle_pkg::*;

  localparam int CB          = COORD_BITS_DEF;
  localparam int FB          = RATIO_FRAC_BITS_DEF;
  localparam int LONG_HOLD   = 600;
  localparam int QUIET_LIMIT = 6000;
  localparam int DRAIN_WAIT  = 120;

  typedef struct {
    logic          kind;
    logic [CB-1:0] point_x;
    logic [CB-1:0] point_y;
    logic [1:0]    crossings;
    logic          last;
  } xing_t;

  // Scoreboard: holds its own copy of the line and the element history and
  // predicts the results that each node transfer causes.
  class xing_scoreboard;
    longint sx, sy, tx, ty;
    bit     new_elem;
    longint fx, fy, fn, ft;
    longint qx, qy, qn, qt;
    longint n_lo, n_hi, t_lo, t_hi;
    xing_t  expected[$];
    int     errors;

    function void clear();
      sx = 0; sy = 0; tx = TIP_X_RESET; ty = 0;
      new_elem = 1;
      fx = 0; fy = 0; fn = 0; ft = 0;
      qx = 0; qy = 0; qn = 0; qt = 0;
      n_lo = 0; n_hi = 0; t_lo = 0; t_hi = 0;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic signed [CB-1:0] v);
      longint val;
      val = v;
      case (idx)
        CFG_START_X: sx = val;
        CFG_START_Y: sy = val;
        CFG_TIP_X:   tx = val;
        CFG_TIP_Y:   ty = val;
      endcase
    endfunction

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // round(n * 2^FB / d), ties up, by restoring division
    function longint crossing_ratio(longint n, longint d);
      longint rem, q;
      rem = n; q = 0;
      for (int i = 0; i < FB; i++) begin
        rem = rem <<< 1;
        q = q <<< 1;
        if (rem >= d) begin
          rem -= d;
          q |= 1;
        end
      end
      if ((rem <<< 1) >= d) q += 1;
      return q;
    endfunction

    function void edge_crossing(longint x1, longint y1, longint n1, longint t1,
                                longint x2, longint y2, longint n2, longint t2);
      longint r, dx, dy, mx, my, px, py;
      xing_t  res;
      if (!((n1 < 0 && n2 > 0) || (n1 > 0 && n2 < 0))) return;
      if (!(t1 < 0 && t2 < 0)) return;
      r  = crossing_ratio(mag(n1), mag(n1) + mag(n2));
      dx = x2 - x1;
      dy = y2 - y1;
      mx = (r * mag(dx) + (longint'(1) <<< (FB - 1))) >>> FB;
      my = (r * mag(dy) + (longint'(1) <<< (FB - 1))) >>> FB;
      px = (dx < 0) ? x1 - mx : x1 + mx;
      py = (dy < 0) ? y1 - my : y1 + my;
      res.kind = 0;
      res.point_x = px[CB-1:0];
      res.point_y = py[CB-1:0];
      res.crossings = 0;
      res.last = 0;
      expected.push_back(res);
    endfunction

    function void note_node(logic signed [CB-1:0] nx, logic signed [CB-1:0] ny, bit lst);
      longint x, y, n, t;
      xing_t  sum;
      x = nx; y = ny;
      n = (sy - ty) * x + (tx - sx) * y + (sx * ty - tx * sy);
      t = (x - tx) * (tx - sx) + (y - ty) * (ty - sy);
      if (new_elem) begin
        fx = x; fy = y; fn = n; ft = t;
        n_lo = n; n_hi = n; t_lo = t; t_hi = t;
      end else begin
        edge_crossing(qx, qy, qn, qt, x, y, n, t);
        if (n < n_lo) n_lo = n;
        if (n > n_hi) n_hi = n;
        if (t < t_lo) t_lo = t;
        if (t > t_hi) t_hi = t;
      end
      if (lst) begin
        edge_crossing(x, y, n, t, fx, fy, fn, ft);
        sum.kind = 1; sum.point_x = 0; sum.point_y = 0; sum.last = 1;
        sum.crossings = 0;
        if (n_hi > 0 && n_lo < 0) begin
          if (t_hi < 0) sum.crossings = 2;
          else if (t_hi > 0 && t_lo < 0) sum.crossings = 1;
        end
        expected.push_back(sum);
      end
      new_elem = lst;
      qx = x; qy = y; qn = n; qt = t;
    endfunction

    function void check_result(xing_t got);
      xing_t want;
      if (expected.size() == 0) begin
        $error("unexpected result kind=%0d x=%0h y=%0h", got.kind, got.point_x,
               got.point_y);
        errors++;
        return;
      end
      want = expected.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind); errors++;
      end
      if (got.point_x !== want.point_x) begin
        $error("point_x: expected %0h, got %0h", want.point_x, got.point_x); errors++;
      end
      if (got.point_y !== want.point_y) begin
        $error("point_y: expected %0h, got %0h", want.point_y, got.point_y); errors++;
      end
      if (got.crossings !== want.crossings) begin
        $error("crossings: expected %0d, got %0d", want.crossings, got.crossings);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last); errors++;
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            cfg_wr_en;
  logic [1:0]      cfg_index;
  logic [CB-1:0]   cfg_data;

  cle_node_if   #(.COORD_BITS(CB)) node_ch ();
  cle_result_if #(.COORD_BITS(CB)) res_ch ();

  crack_line_element_intersection_unit #(
    .COORD_BITS(CB),
    .RATIO_FRAC_BITS(FB)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_node   (node_ch),
    .out_result(res_ch)
  );

  xing_scoreboard sb;
  bit     no_idle;      // both sides skip their random gaps while set
  bit     hold_req;     // ask the receiver for one long hold-off
  int     quiet_cycles;
  longint line_sx, line_sy, line_tx, line_ty;

  initial clk = 0;
  always #4 clk = ~clk;

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((node_ch.valid && node_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stalls, an occasional long hold, then wait for a transfer.
  initial begin
    int    stall;
    xing_t got;
    res_ch.ready <= 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        res_ch.ready <= 0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        res_ch.ready <= 0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
      got.kind      = res_ch.kind;
      got.point_x   = res_ch.point_x;
      got.point_y   = res_ch.point_y;
      got.crossings = res_ch.crossings;
      got.last      = res_ch.last;
      sb.check_result(got);
    end
  end

  // Offer one node and hold it until the transfer; valid stays high when the
  // next node follows without a gap.
  task automatic send_node(logic signed [CB-1:0] x, logic signed [CB-1:0] y, bit lst);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      node_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    node_ch.valid     <= 1;
    node_ch.node_x    <= x;
    node_ch.node_y    <= y;
    node_ch.last_node <= lst;
    do @(posedge clk); while (!node_ch.ready);
    sb.note_node(x, y, lst);
  endtask

  // Drop valid and wait until every expected result has come, then let a
  // node without results finish before touching the registers.
  task automatic drain();
    if (node_ch.valid) node_ch.valid <= 0;
    @(posedge clk);
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_line(longint ax, longint ay, longint bx, longint by);
    logic signed [CB-1:0] v [4];
    drain();
    v[0] = CB'(ax); v[1] = CB'(ay); v[2] = CB'(bx); v[3] = CB'(by);
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= v[i];
      @(posedge clk);
      sb.set_reg(cfg_idx_t'(i), v[i]);
    end
    cfg_wr_en <= 0;
    line_sx = v[0]; line_sy = v[1]; line_tx = v[2]; line_ty = v[3];
  endtask

  function automatic longint clamp_coord(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // Draw a coordinate in a box around the current line, so that many edges
  // straddle it behind the tip; a few draws are anywhere.
  function automatic longint pick_coord(longint a, longint b);
    longint lo, hi, span;
    if ($urandom_range(0, 9) == 0) return longint'($signed($urandom_range(0, 24'hFFFFFF) << 8)) >>> 8;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    span = hi - lo + 64;
    lo = clamp_coord(lo - span);
    hi = clamp_coord(hi + span);
    return lo + longint'($urandom_range(0, 32'hFFFFFFFF)) % (hi - lo + 1);
  endfunction

  task automatic random_elements(int count);
    int sent, len;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 5);
      for (int k = 0; k < len; k++)
        send_node(CB'(pick_coord(line_sx, line_tx)), CB'(pick_coord(line_sy, line_ty)),
                  k == len - 1);
      sent += len;
    end
  endtask

  function automatic longint rand_coord(int bits);
    return longint'($signed($urandom() << (32 - bits))) >>> (32 - bits);
  endfunction

  initial begin
    sb = new();
    sb.clear();
    no_idle = 0;
    hold_req = 0;
    quiet_cycles = 0;
    line_sx = 0; line_sy = 0; line_tx = TIP_X_RESET; line_ty = 0;
    rst_n <= 0;
    cfg_wr_en <= 0;
    cfg_index <= CFG_START_X;
    cfg_data <= 0;
    node_ch.valid <= 0;
    node_ch.node_x <= 0;
    node_ch.node_y <= 0;
    node_ch.last_node <= 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed, reset line from the origin to one unit on x.
    send_node(2048, -4096, 0);          // two crossings, count 2
    send_node(2048, 4096, 1);
    send_node(2048, -4096, 0);          // straddles the tip: count 1
    send_node(8192, 4096, 1);
    send_node(1000, 1000, 1);           // single node element
    send_node(2048, 0, 0);              // zero normal value on the node
    send_node(2048, 4096, 0);
    send_node(1024, -4096, 1);
    send_node(-8388608, -8388608, 0);   // field extremes
    send_node(8388607, 8388607, 0);
    send_node(-8388608, 8388607, 0);
    send_node(8388607, -8388608, 1);
    send_node(-4096, -1, 0);            // crossing far behind the start
    send_node(-4096, 1, 0);
    send_node(-100, 3, 1);

    // Extreme lines, corner to corner in both directions.
    set_line(-8388608, -8388608, 8388607, 8388607);
    send_node(-8388608, 8388607, 0);
    send_node(8388607, -8388608, 0);
    send_node(0, 0, 1);
    random_elements(30);
    set_line(8388607, 8388607, -8388608, -8388608);
    send_node(8388607, -8388608, 0);
    send_node(-8388608, 8388607, 1);
    random_elements(30);

    // Degenerate line: nothing ever crosses.
    set_line(1000, -1000, 1000, -1000);
    send_node(0, 0, 0);
    send_node(5000, 5000, 0);
    send_node(-5000, 5000, 1);

    // Long receiver hold-off while nodes keep coming.
    set_line(0, 0, 0, 40960);
    hold_req = 1;
    no_idle = 1;
    random_elements(30);
    no_idle = 0;

    // Random lines, small and full range.
    for (int p = 0; p < 6; p++) begin
      if (p < 4)
        set_line(rand_coord(16), rand_coord(16), rand_coord(16), rand_coord(16));
      else
        set_line(rand_coord(24), rand_coord(24), rand_coord(24), rand_coord(24));
      no_idle = (p == 2);
      random_elements(30);
    end
    no_idle = 0;

    drain();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
